@@ rtl/cle_pkg.sv @@
package cle_pkg;

	localparam int CLE_CAPACITY   = 32;
	localparam int CLE_DATA_WIDTH = 32;
	localparam int CLE_KEY_WIDTH  = 32;
	localparam int CLE_CMD_WIDTH  = 2;
	localparam int CLE_ST_WIDTH   = 2;
	localparam int CLE_CNT_WIDTH  = 6;

	typedef enum logic [CLE_CMD_WIDTH-1:0] {
		CMD_APPEND  = 2'd0,
		CMD_PREPEND = 2'd1,
		CMD_BEFORE  = 2'd2,
		CMD_DELETE  = 2'd3
	} cmd_t;

	typedef enum logic [CLE_ST_WIDTH-1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_WALK,
		S_ALLOC,
		S_LINK,
		S_JOIN,
		S_UNLINK,
		S_RESP
	} seq_state_t;

	// node store access enables
	typedef struct packed {
		logic rd;
		logic val_we;
		logic nxt_we;
	} node_cmd_t;

endpackage

@@ rtl/cle_node_store.sv @@
module cle_node_store #(
	parameter int CAPACITY   = cle_pkg::CLE_CAPACITY,
	parameter int DATA_WIDTH = cle_pkg::CLE_DATA_WIDTH,
	parameter int IW         = $clog2(CAPACITY)
) (
	input  logic                  clk,
	input  cle_pkg::node_cmd_t    cmd,
	input  logic [IW-1:0]         rd_addr,
	input  logic [IW-1:0]         wr_addr,
	input  logic [DATA_WIDTH-1:0] wr_value,
	input  logic [IW-1:0]         wr_next,
	output logic [DATA_WIDTH-1:0] rd_value,
	output logic [IW-1:0]         rd_next
);
	import cle_pkg::*;

	logic [DATA_WIDTH-1:0] value_mem [CAPACITY];
	logic [IW-1:0]         next_mem  [CAPACITY];

	always_ff @(posedge clk) begin
		if (cmd.val_we) begin
			value_mem[wr_addr] <= wr_value;
		end
		if (cmd.rd) begin
			rd_value <= value_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.nxt_we) begin
			next_mem[wr_addr] <= wr_next;
		end
		if (cmd.rd) begin
			rd_next <= next_mem[rd_addr];
		end
	end

endmodule

@@ rtl/cle_free_stack.sv @@
module cle_free_stack #(
	parameter int CAPACITY = cle_pkg::CLE_CAPACITY,
	parameter int IW       = $clog2(CAPACITY),
	parameter int SW       = $clog2(CAPACITY + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [SW-1:0] size_in,
	input  logic          rd_en,
	input  logic          pop,
	input  logic          push,
	input  logic [IW-1:0] push_addr,
	input  logic [IW-1:0] push_data,
	output logic [IW-1:0] idx
);
	import cle_pkg::*;

	logic [IW-1:0] stk_mem [CAPACITY];
	logic [IW-1:0] rd_q;
	logic [SW-1:0] hw_q;

	// entries at or above the high-water mark were never pushed: index equals position
	always_ff @(posedge clk) begin
		if (push) begin
			stk_mem[push_addr] <= push_data;
		end
		if (rd_en) begin
			rd_q <= stk_mem[IW'(size_in)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= '0;
		end else if (pop && (size_in == hw_q)) begin
			hw_q <= hw_q + SW'(1);
		end
	end

	assign idx = (size_in < hw_q) ? rd_q : IW'(size_in);

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_in <= hw_q)
		else $error("list size above free-stack high-water mark");

	a_push_written: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (SW'(push_addr) < hw_q))
		else $error("push above high-water mark");

	a_read_then_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> pop)
		else $error("free-stack read not followed by allocation");

endmodule

@@ rtl/cle_seq.sv @@
module cle_seq #(
	parameter int CAPACITY   = cle_pkg::CLE_CAPACITY,
	parameter int DATA_WIDTH = cle_pkg::CLE_DATA_WIDTH,
	parameter int IW         = $clog2(CAPACITY),
	parameter int SW         = $clog2(CAPACITY + 1)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [cle_pkg::CLE_CMD_WIDTH-1:0]      command,
	input  logic signed [cle_pkg::CLE_KEY_WIDTH-1:0] key,
	input  logic signed [cle_pkg::CLE_KEY_WIDTH-1:0] value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [cle_pkg::CLE_ST_WIDTH-1:0]       status,
	output logic [cle_pkg::CLE_CNT_WIDTH-1:0]      element_count,
	output cle_pkg::node_cmd_t                     nd_cmd,
	output logic [IW-1:0]                          nd_rd_addr,
	output logic [IW-1:0]                          nd_wr_addr,
	output logic [DATA_WIDTH-1:0]                  nd_wr_value,
	output logic [IW-1:0]                          nd_wr_next,
	input  logic [DATA_WIDTH-1:0]                  nd_rd_value,
	input  logic [IW-1:0]                          nd_rd_next,
	output logic [SW-1:0]                          fs_size,
	output logic                                   fs_rd,
	output logic                                   fs_pop,
	output logic                                   fs_push,
	output logic [IW-1:0]                          fs_push_addr,
	output logic [IW-1:0]                          fs_push_data,
	input  logic [IW-1:0]                          fs_idx
);
	import cle_pkg::*;

	seq_state_t state_q, state_d;

	cmd_t                  cmd_q;
	logic [DATA_WIDTH-1:0] key_q, val_q;
	logic [SW-1:0]         size_q, cnt_q;
	logic [IW-1:0]         tail_q, cur_q, prv_q, hit_q, hnx_q, idx_q;
	logic                  first_q;
	status_t               st_q;
	logic                  out_valid_q;
	status_t               status_q;
	logic [CLE_CNT_WIDTH-1:0] count_q;

	logic signed [63:0]    key_x, val_x;
	cmd_t                  cmd_in;
	logic                  accept, full, empty, insert_end, match, last;

	assign key_x      = 64'(key);
	assign val_x      = 64'(value);
	assign cmd_in     = cmd_t'(command);
	assign accept     = in_valid && !in_stall;
	assign full       = (size_q == SW'(CAPACITY));
	assign empty      = (size_q == '0);
	assign insert_end = (cmd_q == CMD_APPEND) || (cmd_q == CMD_PREPEND);
	assign match      = !first_q && (nd_rd_value == key_q);
	assign last       = (cnt_q + SW'(1)) == size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_stall     = (state_q != S_IDLE);
		nd_cmd       = '0;
		nd_rd_addr   = tail_q;
		nd_wr_addr   = prv_q;
		nd_wr_value  = val_q;
		nd_wr_next   = hnx_q;
		fs_rd        = 1'b0;
		fs_pop       = 1'b0;
		fs_push      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if ((cmd_in == CMD_APPEND) || (cmd_in == CMD_PREPEND)) begin
						state_d = full ? S_RESP : (empty ? S_ALLOC : S_HEAD);
					end else begin
						state_d = empty ? S_RESP : S_HEAD;
					end
				end
			end
			S_HEAD: begin
				nd_cmd.rd  = 1'b1;
				nd_rd_addr = tail_q;
				state_d    = insert_end ? S_ALLOC : S_WALK;
			end
			S_WALK: begin
				nd_cmd.rd  = 1'b1;
				nd_rd_addr = nd_rd_next;
				if (match) begin
					if (cmd_q == CMD_DELETE) begin
						state_d = S_UNLINK;
					end else begin
						state_d = full ? S_RESP : S_ALLOC;
					end
				end else if (!first_q && last) begin
					state_d = S_RESP;
				end
			end
			S_ALLOC: begin
				fs_rd   = 1'b1;
				state_d = S_LINK;
			end
			S_LINK: begin
				nd_cmd.val_we = 1'b1;
				nd_cmd.nxt_we = 1'b1;
				nd_wr_addr    = fs_idx;
				nd_wr_next    = empty ? fs_idx : hit_q;
				fs_pop        = 1'b1;
				state_d       = S_JOIN;
			end
			S_JOIN: begin
				nd_cmd.nxt_we = !empty;
				nd_wr_addr    = prv_q;
				nd_wr_next    = idx_q;
				state_d       = S_RESP;
			end
			S_UNLINK: begin
				nd_cmd.nxt_we = (size_q != SW'(1));
				nd_wr_addr    = prv_q;
				nd_wr_next    = hnx_q;
				fs_push       = 1'b1;
				state_d       = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign fs_size      = size_q;
	assign fs_push_addr = IW'(size_q - SW'(1));
	assign fs_push_data = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_JOIN) begin
				size_q <= size_q + SW'(1);
				if (empty || (cmd_q == CMD_APPEND)) begin
					tail_q <= idx_q;
				end
			end
			if (state_q == S_UNLINK) begin
				size_q <= size_q - SW'(1);
				if (size_q == SW'(1)) begin
					tail_q <= '0;
				end else if (hit_q == tail_q) begin
					tail_q <= prv_q;
				end
			end
			if ((state_q == S_RESP) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q <= cmd_in;
					key_q <= key_x[DATA_WIDTH-1:0];
					val_q <= val_x[DATA_WIDTH-1:0];
					st_q  <= ((cmd_in == CMD_APPEND) || (cmd_in == CMD_PREPEND)) ?
						ST_FULL : ST_MISS;
				end
			end
			S_HEAD: begin
				cur_q   <= tail_q;
				first_q <= 1'b1;
				cnt_q   <= '0;
			end
			S_WALK: begin
				if (match) begin
					hit_q <= cur_q;
					hnx_q <= nd_rd_next;
					st_q  <= ST_FULL;
				end else begin
					prv_q   <= cur_q;
					cur_q   <= nd_rd_next;
					first_q <= 1'b0;
					st_q    <= ST_MISS;
					if (!first_q) begin
						cnt_q <= cnt_q + SW'(1);
					end
				end
			end
			S_ALLOC: begin
				if (insert_end) begin
					prv_q <= tail_q;
					hit_q <= nd_rd_next;
				end
			end
			S_LINK: begin
				idx_q <= fs_idx;
			end
			S_JOIN, S_UNLINK: begin
				st_q <= ST_DONE;
			end
			S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					status_q <= st_q;
					count_q  <= CLE_CNT_WIDTH'(size_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign element_count = count_q;

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= SW'(CAPACITY))
		else $error("list size above capacity");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result raised outside response state");

	a_link_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINK) |-> !full)
		else $error("node linked into a full store");

endmodule

@@ rtl/circular_list_engine_core.sv @@
// Append and insert head read the head, then allocate, link and join before the response;
// on an empty list they skip the head read. Insert-before and delete read the head, walk
// comparing k nodes (1..list size) to a match or the list end, then allocate, link and
// join, or unlink. A miss, a full store on an insert, or an empty list on insert-before or
// delete goes straight to the response. The walk reads one entry per cycle; one item at a time.
// Reset: asynchronous, list empty with every node free; node memories undefined until written.
module circular_list_engine_core #(
	parameter int CAPACITY   = cle_pkg::CLE_CAPACITY,
	parameter int DATA_WIDTH = cle_pkg::CLE_DATA_WIDTH
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [cle_pkg::CLE_CMD_WIDTH-1:0]        command,
	input  logic signed [cle_pkg::CLE_KEY_WIDTH-1:0] key,
	input  logic signed [cle_pkg::CLE_KEY_WIDTH-1:0] value,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [cle_pkg::CLE_ST_WIDTH-1:0]         status,
	output logic [cle_pkg::CLE_CNT_WIDTH-1:0]        element_count
);
	import cle_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int SW = $clog2(CAPACITY + 1);

	node_cmd_t             nd_cmd;
	logic [IW-1:0]         nd_rd_addr, nd_wr_addr, nd_wr_next, nd_rd_next;
	logic [DATA_WIDTH-1:0] nd_wr_value, nd_rd_value;
	logic [SW-1:0]         fs_size;
	logic                  fs_rd, fs_pop, fs_push;
	logic [IW-1:0]         fs_push_addr, fs_push_data, fs_idx;

	cle_node_store #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH),
		.IW         (IW)
	) u_nodes (
		.clk      (clk),
		.cmd      (nd_cmd),
		.rd_addr  (nd_rd_addr),
		.wr_addr  (nd_wr_addr),
		.wr_value (nd_wr_value),
		.wr_next  (nd_wr_next),
		.rd_value (nd_rd_value),
		.rd_next  (nd_rd_next)
	);

	cle_free_stack #(
		.CAPACITY (CAPACITY),
		.IW       (IW),
		.SW       (SW)
	) u_free (
		.clk       (clk),
		.arst_n    (arst_n),
		.size_in   (fs_size),
		.rd_en     (fs_rd),
		.pop       (fs_pop),
		.push      (fs_push),
		.push_addr (fs_push_addr),
		.push_data (fs_push_data),
		.idx       (fs_idx)
	);

	cle_seq #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH),
		.IW         (IW),
		.SW         (SW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.key           (key),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.element_count (element_count),
		.nd_cmd        (nd_cmd),
		.nd_rd_addr    (nd_rd_addr),
		.nd_wr_addr    (nd_wr_addr),
		.nd_wr_value   (nd_wr_value),
		.nd_wr_next    (nd_wr_next),
		.nd_rd_value   (nd_rd_value),
		.nd_rd_next    (nd_rd_next),
		.fs_size       (fs_size),
		.fs_rd         (fs_rd),
		.fs_pop        (fs_pop),
		.fs_push       (fs_push),
		.fs_push_addr  (fs_push_addr),
		.fs_push_data  (fs_push_data),
		.fs_idx        (fs_idx)
	);

endmodule
